[hw/rtl/tpi_pkg.sv]
`timescale 1ns / 1ps
package tpi_pkg;

  localparam int BUCKETS_DEF   = 1024;
  localparam int POOL_DEF      = 4096;
  localparam int MAX_RUN_DEF   = 64;
  localparam int KEY_BYTES_DEF = 32;

  localparam int CFG_W   = 11;
  localparam int ENTRY_W = 13;
  localparam int HASH_W  = 64;
  localparam int WORD_W  = 64;
  localparam int COUNT_W = 7;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_USED  = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_POOL_FULL  = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_NOT_FOUND  = 2'd3
  } status_e;

endpackage

[hw/rtl/tpi_ram.sv]
`timescale 1ns / 1ps
module tpi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/tag_posting_index.sv]
`timescale 1ns / 1ps
// channel   | handshake             | payload
// ----------+-----------------------+------------------------------------------------
// in        | in_valid_i/in_ready_o | operation, key_name, key_word0..3, event_ref,
//           |                       | stamp, since_bound, until_bound, max_matches
// out       | out_valid_o/out_ready_i | status, match_ref, match_stamp, match_count, last
// cfg       | cfg_we_i              | cfg_wdata_i (buckets_in_use)
//
// one item at a time: a bit-serial hash modulo, then a read and a check per bucket
// probed in the slot ram, and a read and a check per list entry walked in the pool ram
// a pool-full insert skips the hash and the probe and goes straight to its answer
// after reset a clearing pass writes all BUCKETS slot entries, one per cycle
// a result waits in the output register and the next in a pending register; the walk
// stalls only when it finds another match before the output register was taken
module tag_posting_index #(
  parameter int BUCKETS      = tpi_pkg::BUCKETS_DEF,
  parameter int POOL_ENTRIES = tpi_pkg::POOL_DEF,
  parameter int MAX_RUN      = tpi_pkg::MAX_RUN_DEF,
  parameter int KEY_BYTES    = tpi_pkg::KEY_BYTES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              operation_i,
  input  logic [7:0]                        key_name_i,
  input  logic [tpi_pkg::WORD_W-1:0]        key_word0_i,
  input  logic [tpi_pkg::WORD_W-1:0]        key_word1_i,
  input  logic [tpi_pkg::WORD_W-1:0]        key_word2_i,
  input  logic [tpi_pkg::WORD_W-1:0]        key_word3_i,
  input  logic [tpi_pkg::WORD_W-1:0]        event_ref_i,
  input  logic signed [tpi_pkg::WORD_W-1:0] stamp_i,
  input  logic signed [tpi_pkg::WORD_W-1:0] since_bound_i,
  input  logic signed [tpi_pkg::WORD_W-1:0] until_bound_i,
  input  logic [tpi_pkg::COUNT_W-1:0]       max_matches_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic [tpi_pkg::WORD_W-1:0]        match_ref_o,
  output logic signed [tpi_pkg::WORD_W-1:0] match_stamp_o,
  output logic [tpi_pkg::COUNT_W-1:0]       match_count_o,
  output logic                              last_o,
  input  logic                              cfg_we_i,
  input  logic [tpi_pkg::CFG_W-1:0]         cfg_wdata_i
);

  import tpi_pkg::*;

  localparam int BW  = $clog2(BUCKETS);
  localparam int NW  = $clog2(BUCKETS + 1);
  localparam int PW  = $clog2(POOL_ENTRIES);
  localparam int FW  = $clog2(POOL_ENTRIES + 1);
  localparam int KW  = KEY_BYTES * 8;
  localparam int DCW = $clog2(HASH_W);

  typedef struct packed {
    logic [1:0]         st;
    logic [7:0]         name;
    logic [KW-1:0]      key;
    logic [PW-1:0]      head;
    logic [ENTRY_W-1:0] cnt;
  } slot_t;

  typedef struct packed {
    logic [WORD_W-1:0] ref_v;
    logic [WORD_W-1:0] stamp;
    logic [PW-1:0]     older;
  } pool_t;

  typedef enum logic [8:0] {
    S_CLEAR   = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_HASH    = 9'b000000100,
    S_PRB_RD  = 9'b000001000,
    S_PRB_CHK = 9'b000010000,
    S_ACT     = 9'b000100000,
    S_WLK_RD  = 9'b001000000,
    S_WLK_CHK = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [CFG_W-1:0] cfg_q;
  logic [BW-1:0]    clr_q, clr_d;
  logic [FW-1:0]    nf_q, nf_d;

  // item registers
  logic                     op_q;
  logic [7:0]               name_q;
  logic [KW-1:0]            key_q;
  logic [WORD_W-1:0]        ref_q;
  logic [WORD_W-1:0]        stamp_q;
  logic signed [WORD_W-1:0] since_q, until_q;
  logic [COUNT_W-1:0]       lim_q;
  logic [NW-1:0]            n_q;

  // search
  logic [HASH_W-1:0]  hsh_q, hsh_d;
  logic [DCW-1:0]     dcnt_q, dcnt_d;
  logic [NW-1:0]      rem_q, rem_d;
  logic [BW-1:0]      idx_q, idx_d;
  logic [NW-1:0]      k_q, k_d;
  logic               found_q, found_d;
  logic               hfree_q, hfree_d;
  logic [BW-1:0]      free_q, free_d;
  logic [BW-1:0]      bkt_q, bkt_d;
  logic [PW-1:0]      head_q, head_d;
  logic [ENTRY_W-1:0] ent_q, ent_d;

  // walk
  logic [PW-1:0]       e_q, e_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;
  logic                hpend_q, hpend_d;
  logic [WORD_W-1:0]   pref_q, pref_d;
  logic [WORD_W-1:0]   pstamp_q, pstamp_d;
  logic [COUNT_W-1:0]  pcnt_q, pcnt_d;
  status_e             fin_q, fin_d;

  // output register
  logic               ovalid_q, ovalid_d;
  status_e            ostat_q, ostat_d;
  logic [WORD_W-1:0]  oref_q, oref_d;
  logic [WORD_W-1:0]  ostamp_q, ostamp_d;
  logic [COUNT_W-1:0] ocnt_q, ocnt_d;
  logic               olast_q, olast_d;

  // memories
  logic          s_we, s_re;
  logic [BW-1:0] s_waddr;
  slot_t         s_wdata, s_rdata;
  logic          p_we, p_re;
  logic [PW-1:0] p_waddr;
  pool_t         p_wdata, p_rdata;

  logic                   accept, can_push;
  logic [4*WORD_W-1:0]    key_all;
  logic [NW-1:0]          n_cur;
  logic [COUNT_W-1:0]     lim_cur;
  logic [NW:0]            dtmp;
  logic [BW-1:0]          idx_nx;
  logic                   key_eq, keep, since_on, until_on;
  logic [COUNT_W-1:0]     cnt_nx;

  tpi_ram #(.WIDTH($bits(slot_t)), .DEPTH(BUCKETS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (idx_q),
    .rdata_o (s_rdata)
  );

  tpi_ram #(.WIDTH($bits(pool_t)), .DEPTH(POOL_ENTRIES)) u_pool_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .re_i    (p_re),
    .raddr_i (e_q),
    .rdata_o (p_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign can_push   = !ovalid_q || out_ready_i;
  assign key_all    = {key_word3_i, key_word2_i, key_word1_i, key_word0_i};

  always_comb begin
    if (cfg_q == '0) begin
      n_cur = NW'(1);
    end else if (32'(cfg_q) > 32'(BUCKETS)) begin
      n_cur = NW'(BUCKETS);
    end else begin
      n_cur = NW'(cfg_q);
    end
    if (max_matches_i == '0 || 32'(max_matches_i) > 32'(MAX_RUN)) begin
      lim_cur = COUNT_W'(MAX_RUN);
    end else begin
      lim_cur = max_matches_i;
    end
  end

  assign dtmp   = {rem_q, hsh_q[HASH_W-1]};
  assign idx_nx = (NW'(idx_q) + NW'(1) == n_q) ? '0 : idx_q + BW'(1);
  assign key_eq = (s_rdata.name == name_q) && (s_rdata.key == key_q);

  assign since_on = !since_q[WORD_W-1] && (since_q != '0);
  assign until_on = !until_q[WORD_W-1] && (until_q != '0);
  assign keep = !(since_on && ($signed(p_rdata.stamp) < since_q))
             && !(until_on && (until_q < $signed(p_rdata.stamp)));
  assign cnt_nx = cnt_q + COUNT_W'(1);

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    nf_d     = nf_q;
    hsh_d    = hsh_q;
    dcnt_d   = dcnt_q;
    rem_d    = rem_q;
    idx_d    = idx_q;
    k_d      = k_q;
    found_d  = found_q;
    hfree_d  = hfree_q;
    free_d   = free_q;
    bkt_d    = bkt_q;
    head_d   = head_q;
    ent_d    = ent_q;
    e_d      = e_q;
    cnt_d    = cnt_q;
    hpend_d  = hpend_q;
    pref_d   = pref_q;
    pstamp_d = pstamp_q;
    pcnt_d   = pcnt_q;
    fin_d    = fin_q;
    ovalid_d = ovalid_q && !out_ready_i;
    ostat_d  = ostat_q;
    oref_d   = oref_q;
    ostamp_d = ostamp_q;
    ocnt_d   = ocnt_q;
    olast_d  = olast_q;
    s_we     = 1'b0;
    s_re     = 1'b0;
    s_waddr  = bkt_q;
    s_wdata  = '0;
    p_we     = 1'b0;
    p_re     = 1'b0;
    p_waddr  = nf_q[PW-1:0];
    p_wdata  = '0;

    unique case (state_q)
      S_CLEAR: begin
        s_we    = 1'b1;
        s_waddr = clr_q;
        clr_d   = clr_q + BW'(1);
        if (32'(clr_q) == BUCKETS - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          hpend_d = 1'b0;
          cnt_d   = '0;
          found_d = 1'b0;
          hfree_d = 1'b0;
          rem_d   = '0;
          dcnt_d  = '0;
          hsh_d   = {key_word0_i[HASH_W-9:0], key_name_i};
          if (operation_i == OP_INSERT && 32'(nf_q) >= POOL_ENTRIES) begin
            fin_d   = ST_POOL_FULL;
            state_d = S_DONE;
          end else begin
            state_d = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (dtmp >= {1'b0, n_q}) begin
          rem_d = NW'(dtmp - {1'b0, n_q});
        end else begin
          rem_d = NW'(dtmp);
        end
        hsh_d  = hsh_q << 1;
        dcnt_d = dcnt_q + DCW'(1);
        if (dcnt_q == DCW'(HASH_W - 1)) begin
          idx_d   = rem_d[BW-1:0];
          k_d     = '0;
          state_d = S_PRB_RD;
        end
      end
      S_PRB_RD: begin
        s_re    = 1'b1;
        state_d = S_PRB_CHK;
      end
      S_PRB_CHK: begin
        if (s_rdata.st == SLOT_EMPTY) begin
          if (!hfree_q) begin
            hfree_d = 1'b1;
            free_d  = idx_q;
          end
          state_d = S_ACT;
        end else if (s_rdata.st == SLOT_USED && key_eq) begin
          found_d = 1'b1;
          bkt_d   = idx_q;
          head_d  = s_rdata.head;
          ent_d   = s_rdata.cnt;
          state_d = S_ACT;
        end else begin
          if (s_rdata.st == SLOT_TOMB && !hfree_q) begin
            hfree_d = 1'b1;
            free_d  = idx_q;
          end
          k_d = k_q + NW'(1);
          if (k_q + NW'(1) == n_q) begin
            state_d = S_ACT;
          end else begin
            idx_d   = idx_nx;
            state_d = S_PRB_RD;
          end
        end
      end
      S_ACT: begin
        if (op_q == OP_INSERT) begin
          if (found_q || hfree_q) begin
            p_we          = 1'b1;
            p_wdata.ref_v = ref_q;
            p_wdata.stamp = stamp_q;
            p_wdata.older = found_q ? head_q : '0;
            s_we          = 1'b1;
            s_waddr       = found_q ? bkt_q : free_q;
            s_wdata.st    = SLOT_USED;
            s_wdata.name  = name_q;
            s_wdata.key   = key_q;
            s_wdata.head  = nf_q[PW-1:0];
            s_wdata.cnt   = found_q ? ent_q + ENTRY_W'(1) : ENTRY_W'(1);
            nf_d          = nf_q + FW'(1);
            fin_d         = ST_OK;
          end else begin
            fin_d = ST_TABLE_FULL;
          end
          state_d = S_DONE;
        end else if (found_q && ent_q != '0 && head_q != '0) begin
          e_d     = head_q;
          state_d = S_WLK_RD;
        end else begin
          fin_d   = ST_NOT_FOUND;
          state_d = S_DONE;
        end
      end
      S_WLK_RD: begin
        p_re    = 1'b1;
        state_d = S_WLK_CHK;
      end
      S_WLK_CHK: begin
        if (keep) begin
          if (!hpend_q || can_push) begin
            if (hpend_q) begin
              ovalid_d = 1'b1;
              ostat_d  = ST_OK;
              oref_d   = pref_q;
              ostamp_d = pstamp_q;
              ocnt_d   = pcnt_q;
              olast_d  = 1'b0;
            end
            hpend_d  = 1'b1;
            pref_d   = p_rdata.ref_v;
            pstamp_d = p_rdata.stamp;
            pcnt_d   = cnt_nx;
            cnt_d    = cnt_nx;
            if (cnt_nx == lim_q || p_rdata.older == '0) begin
              state_d = S_DONE;
            end else begin
              e_d     = p_rdata.older;
              state_d = S_WLK_RD;
            end
          end
        end else if (p_rdata.older == '0) begin
          fin_d   = ST_NOT_FOUND;
          state_d = S_DONE;
        end else begin
          e_d     = p_rdata.older;
          state_d = S_WLK_RD;
        end
      end
      S_DONE: begin
        if (can_push) begin
          ovalid_d = 1'b1;
          olast_d  = 1'b1;
          if (hpend_q) begin
            ostat_d  = ST_OK;
            oref_d   = pref_q;
            ostamp_d = pstamp_q;
            ocnt_d   = pcnt_q;
          end else begin
            ostat_d  = (op_q == OP_QUERY) ? ST_NOT_FOUND : fin_q;
            oref_d   = '0;
            ostamp_d = '0;
            ocnt_d   = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      nf_q     <= FW'(1);
      cfg_q    <= CFG_W'(1024);
      ovalid_q <= 1'b0;
      hpend_q  <= 1'b0;
      cnt_q    <= '0;
      dcnt_q   <= '0;
      k_q      <= '0;
      found_q  <= 1'b0;
      hfree_q  <= 1'b0;
      fin_q    <= ST_OK;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      nf_q     <= nf_d;
      ovalid_q <= ovalid_d;
      hpend_q  <= hpend_d;
      cnt_q    <= cnt_d;
      dcnt_q   <= dcnt_d;
      k_q      <= k_d;
      found_q  <= found_d;
      hfree_q  <= hfree_d;
      fin_q    <= fin_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= operation_i;
      name_q  <= key_name_i;
      key_q   <= key_all[KW-1:0];
      ref_q   <= event_ref_i;
      stamp_q <= stamp_i;
      since_q <= since_bound_i;
      until_q <= until_bound_i;
      lim_q   <= lim_cur;
      n_q     <= n_cur;
    end
    hsh_q    <= hsh_d;
    rem_q    <= rem_d;
    idx_q    <= idx_d;
    free_q   <= free_d;
    bkt_q    <= bkt_d;
    head_q   <= head_d;
    ent_q    <= ent_d;
    e_q      <= e_d;
    pref_q   <= pref_d;
    pstamp_q <= pstamp_d;
    pcnt_q   <= pcnt_d;
    ostat_q  <= ostat_d;
    oref_q   <= oref_d;
    ostamp_q <= ostamp_d;
    ocnt_q   <= ocnt_d;
    olast_q  <= olast_d;
  end

  assign out_valid_o   = ovalid_q;
  assign status_o      = ostat_q;
  assign match_ref_o   = oref_q;
  assign match_stamp_o = ostamp_q;
  assign match_count_o = ocnt_q;
  assign last_o        = olast_q;

`ifndef SYNTHESIS
  a_nf_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(nf_q) <= POOL_ENTRIES)
    else $error("pool allocation pointer past end");

  a_pool_we_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_we |-> (32'(nf_q) < POOL_ENTRIES) && (nf_q != '0))
    else $error("pool write without free entry");

  a_not_found_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_NOT_FOUND) |-> (last_o && match_count_o == '0))
    else $error("not found result malformed");

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hpend_q && state_q != S_IDLE) |-> (cnt_q <= lim_q && cnt_q != '0))
    else $error("match count beyond limit");
`endif

endmodule

[verif/tpi_checker.sv]
`timescale 1ns / 1ps
module tpi_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               operation_i,
  input  logic [7:0]         key_name_i,
  input  logic [63:0]        key_word0_i,
  input  logic [63:0]        key_word1_i,
  input  logic [63:0]        key_word2_i,
  input  logic [63:0]        key_word3_i,
  input  logic [63:0]        event_ref_i,
  input  logic signed [63:0] stamp_i,
  input  logic signed [63:0] since_bound_i,
  input  logic signed [63:0] until_bound_i,
  input  logic [6:0]         max_matches_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [1:0]         status_i,
  input  logic [63:0]        match_ref_i,
  input  logic signed [63:0] match_stamp_i,
  input  logic [6:0]         match_count_i,
  input  logic               last_i,
  input  logic               cfg_we_i,
  input  logic [10:0]        cfg_wdata_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import tpi_pkg::*;

  localparam int NB = BUCKETS_DEF;
  localparam int NP = POOL_DEF;

  typedef struct packed {
    status_e            status;
    logic [63:0]        ref_v;
    logic signed [63:0] stamp_v;
    logic [6:0]         count;
    logic               last;
  } posting_t;

  posting_t    postings_due[$];
  logic [10:0] bucket_cfg;
  logic [1:0]  slot_st [NB];
  logic [7:0]  slot_nm [NB];
  logic [63:0] slot_kv [NB][4];
  logic [12:0] slot_hd [NB];
  logic [12:0] slot_cnt [NB];
  logic [63:0]        pool_rf [NP];
  logic signed [63:0] pool_sp [NP];
  logic [12:0]        pool_nx [NP];
  logic [12:0]        next_free;

  assign pending_o = postings_due.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  task automatic push(input status_e s, input logic [63:0] r, input logic [63:0] sp,
                      input logic [6:0] c, input logic l);
    posting_t p;
    p.status = s; p.ref_v = r; p.stamp_v = sp; p.count = c; p.last = l;
    postings_due.push_back(p);
  endtask

  task automatic predict_postings();
    logic [63:0] kv [4];
    logic [63:0] hash;
    int n, start, idx, hit, cnt, lim;
    logic [12:0] e;
    logic since_on, until_on, keep;
    kv[0] = key_word0_i; kv[1] = key_word1_i; kv[2] = key_word2_i; kv[3] = key_word3_i;
    n = bucket_cfg;
    if (n == 0) n = 1;
    if (n > NB) n = NB;
    hash = {56'd0, key_name_i} | (kv[0] << 8);
    start = int'(hash % 64'(n));
    hit = -1;
    idx = start;
    for (int k = 0; k < n; k++) begin
      if (slot_st[idx] == SLOT_EMPTY) break;
      if (slot_st[idx] == SLOT_USED && slot_nm[idx] == key_name_i && slot_kv[idx][0] == kv[0]
          && slot_kv[idx][1] == kv[1] && slot_kv[idx][2] == kv[2]
          && slot_kv[idx][3] == kv[3]) begin
        hit = idx;
        break;
      end
      idx = (idx + 1) % n;
    end
    if (operation_i == OP_INSERT) begin
      if (next_free >= NP) begin
        push(ST_POOL_FULL, 0, 0, 0, 1);
        return;
      end
      if (hit < 0) begin
        idx = start;
        for (int k = 0; k < n; k++) begin
          if (slot_st[idx] == SLOT_EMPTY || slot_st[idx] == SLOT_TOMB) begin
            hit = idx;
            break;
          end
          idx = (idx + 1) % n;
        end
        if (hit < 0) begin
          push(ST_TABLE_FULL, 0, 0, 0, 1);
          return;
        end
        slot_nm[hit] = key_name_i;
        for (int w = 0; w < 4; w++) slot_kv[hit][w] = kv[w];
        slot_hd[hit] = 0;
        slot_cnt[hit] = 0;
        slot_st[hit] = SLOT_USED;
      end
      e = next_free;
      next_free++;
      pool_rf[e] = event_ref_i;
      pool_sp[e] = stamp_i;
      pool_nx[e] = slot_hd[hit];
      slot_hd[hit] = e;
      slot_cnt[hit] = slot_cnt[hit] + 1;
      push(ST_OK, 0, 0, 0, 1);
    end else begin
      since_on = since_bound_i > 0;
      until_on = until_bound_i > 0;
      lim = max_matches_i;
      if (lim == 0 || lim > MAX_RUN_DEF) lim = MAX_RUN_DEF;
      cnt = 0;
      if (hit >= 0 && slot_cnt[hit] != 0) begin
        e = slot_hd[hit];
        while (e != 0 && cnt < lim) begin
          keep = 1'b1;
          if (since_on && pool_sp[e] < since_bound_i) keep = 1'b0;
          if (until_on && until_bound_i < pool_sp[e]) keep = 1'b0;
          if (keep) begin
            cnt++;
            push(ST_OK, pool_rf[e], pool_sp[e], 7'(cnt), 0);
          end
          e = pool_nx[e];
        end
      end
      if (cnt == 0) push(ST_NOT_FOUND, 0, 0, 0, 1);
      else postings_due[$].last = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    posting_t want;
    if (!rst_ni) begin
      bucket_cfg = 11'd1024;
      next_free = 1;
      for (int i = 0; i < NB; i++) begin
        slot_st[i] = SLOT_EMPTY; slot_nm[i] = 0; slot_hd[i] = 0; slot_cnt[i] = 0;
        for (int w = 0; w < 4; w++) slot_kv[i][w] = 0;
      end
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (postings_due.size() == 0) begin
          report("unexpected item", status_i, 0);
        end else begin
          want = postings_due.pop_front();
          if (status_i != want.status) report("status", status_i, want.status);
          if (match_ref_i != want.ref_v) report("match_ref", match_ref_i, want.ref_v);
          if (match_stamp_i != want.stamp_v) report("match_stamp", match_stamp_i, want.stamp_v);
          if (match_count_i != want.count) report("match_count", match_count_i, want.count);
          if (last_i != want.last) report("last", last_i, want.last);
        end
      end
      if (in_valid_i && in_ready_i) predict_postings();
      if (cfg_we_i) bucket_cfg = cfg_wdata_i;
    end
  end

  initial fail_count_o = 0;

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import tpi_pkg::*;

  logic clk_i, rst_ni;
  logic in_valid, in_ready, out_valid, out_ready;
  logic op;
  logic [7:0] key_name;
  logic [63:0] kw [4];
  logic [63:0] event_ref;
  logic signed [63:0] stamp, since_b, until_b;
  logic [6:0] max_m;
  logic [1:0] status;
  logic [63:0] match_ref;
  logic signed [63:0] match_stamp;
  logic [6:0] match_count;
  logic last;
  logic cfg_we;
  logic [10:0] cfg_wdata;
  int fail_count, pending;

  logic [7:0]  pool_nm [8];
  logic [63:0] pool_kw [8][4];
  int burst_left;
  bit no_gap, hold_rx;

  tag_posting_index dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .operation_i(op), .key_name_i(key_name),
    .key_word0_i(kw[0]), .key_word1_i(kw[1]), .key_word2_i(kw[2]), .key_word3_i(kw[3]),
    .event_ref_i(event_ref), .stamp_i(stamp), .since_bound_i(since_b),
    .until_bound_i(until_b), .max_matches_i(max_m),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .match_ref_o(match_ref), .match_stamp_o(match_stamp),
    .match_count_o(match_count), .last_o(last),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata)
  );

  tpi_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid), .in_ready_i(in_ready),
    .operation_i(op), .key_name_i(key_name),
    .key_word0_i(kw[0]), .key_word1_i(kw[1]), .key_word2_i(kw[2]), .key_word3_i(kw[3]),
    .event_ref_i(event_ref), .stamp_i(stamp), .since_bound_i(since_b),
    .until_bound_i(until_b), .max_matches_i(max_m),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .status_i(status),
    .match_ref_i(match_ref), .match_stamp_i(match_stamp), .match_count_i(match_count),
    .last_i(last), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic signed [63:0] rand_time();
    case ($urandom_range(0, 5))
      0: return rand64();
      1: return 0;
      2: return -$signed(64'($urandom_range(1, 60)));
      default: return $signed(64'($urandom_range(1, 120)));
    endcase
  endfunction

  task automatic send(input logic o, input logic [7:0] nm, input logic [63:0] w0,
                      input logic [63:0] w1, input logic [63:0] w2, input logic [63:0] w3,
                      input logic [63:0] er, input logic signed [63:0] sp,
                      input logic signed [63:0] sb, input logic signed [63:0] ub,
                      input logic [6:0] mm);
    @(negedge clk_i);
    op = o; key_name = nm; kw[0] = w0; kw[1] = w1; kw[2] = w2; kw[3] = w3;
    event_ref = er; stamp = sp; since_b = sb; until_b = ub; max_m = mm;
    in_valid = 1'b1;
    do @(posedge clk_i); while (!in_ready);
    if (no_gap) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk_i);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = $urandom_range(0, 10);
    end
  endtask

  task automatic send_pool(input logic o, input int k, input logic signed [63:0] sp,
                           input logic signed [63:0] sb, input logic signed [63:0] ub,
                           input logic [6:0] mm);
    send(o, pool_nm[k], pool_kw[k][0], pool_kw[k][1], pool_kw[k][2], pool_kw[k][3],
         rand64(), sp, sb, ub, mm);
  endtask

  task automatic send_random();
    int k;
    logic o;
    o = ($urandom_range(0, 9) < 6) ? OP_INSERT : OP_QUERY;
    if ($urandom_range(0, 9) < 8) begin
      k = $urandom_range(0, 7);
      send_pool(o, k, rand_time(), rand_time(), rand_time(), 7'($urandom_range(0, 127)));
    end else begin
      send(o, 8'($urandom), rand64(), rand64(), rand64(), rand64(), rand64(), rand_time(),
           rand_time(), rand_time(), 7'($urandom_range(0, 127)));
    end
  endtask

  task automatic settle_and_cfg(input logic [10:0] value);
    @(negedge clk_i);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (20) @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // receiver stall pattern, with one long hold when asked
  initial begin
    int mode;
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(10, 80)) begin
        @(negedge clk_i);
        if (hold_rx) begin
          out_ready = 1'b0;
          repeat (400) @(negedge clk_i);
          hold_rx = 1'b0;
        end
        case (mode)
          0: out_ready = 1'b1;
          1: out_ready = $urandom_range(0, 1);
          default: out_ready = ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  initial begin
    #40ms;
    $display("** tag_posting_index: FAILED **");
    $finish;
  end

  initial begin
    logic [63:0] ones;
    ones = '1;
    rst_ni = 1'b0;
    in_valid = 1'b0; op = OP_INSERT; key_name = 0;
    kw[0] = 0; kw[1] = 0; kw[2] = 0; kw[3] = 0;
    event_ref = 0; stamp = 0; since_b = 0; until_b = 0; max_m = 0;
    cfg_we = 1'b0; cfg_wdata = 0;
    burst_left = 0; no_gap = 0; hold_rx = 0;
    for (int k = 0; k < 8; k++) begin
      pool_nm[k] = 8'($urandom);
      for (int w = 0; w < 4; w++) pool_kw[k][w] = rand64();
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, filters, limits, not found
    settle_and_cfg(11'd2047);
    send_pool(OP_INSERT, 0, 0, 0, 0, 0);
    send(OP_INSERT, pool_nm[0], pool_kw[0][0], pool_kw[0][1], pool_kw[0][2], pool_kw[0][3],
         ones, 64'sh7fffffffffffffff, 0, 0, 0);
    send(OP_INSERT, pool_nm[0], pool_kw[0][0], pool_kw[0][1], pool_kw[0][2], pool_kw[0][3],
         0, 64'sh8000000000000000, 0, 0, 0);
    send_pool(OP_INSERT, 0, 50, 0, 0, 0);
    send(OP_INSERT, 8'hff, ones, ones, ones, ones, ones, 7, 0, 0, 0);
    send(OP_INSERT, 8'h00, 0, 0, 0, 0, 0, -7, 0, 0, 0);
    send_pool(OP_QUERY, 0, 0, 0, 0, 7'd0);
    send_pool(OP_QUERY, 0, 0, 0, 0, 7'd1);
    send_pool(OP_QUERY, 0, 0, 0, 0, 7'd64);
    send_pool(OP_QUERY, 0, 0, 0, 0, 7'd127);
    send_pool(OP_QUERY, 0, 0, 10, 0, 7'd0);
    send_pool(OP_QUERY, 0, 0, -5, 60, 7'd0);
    send_pool(OP_QUERY, 0, 0, 64'sh8000000000000000, 64'sh7fffffffffffffff, 7'd0);
    send_pool(OP_QUERY, 0, 0, 51, 52, 7'd0);
    send(OP_QUERY, 8'hff, ones, ones, ones, ones, 0, 0, 0, 0, 0);
    send(OP_QUERY, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_pool(OP_QUERY, 1, 0, 0, 0, 7'd5);

    // table full with a single bucket
    settle_and_cfg(11'd1);
    send_pool(OP_INSERT, 2, 3, 0, 0, 0);
    send_pool(OP_INSERT, 3, 4, 0, 0, 0);
    send_pool(OP_QUERY, 3, 0, 0, 0, 0);
    send_pool(OP_QUERY, 2, 0, 0, 0, 0);
    settle_and_cfg(11'd0);
    send_pool(OP_INSERT, 4, 5, 0, 0, 0);
    send_pool(OP_INSERT, 2, 6, 0, 0, 0);

    // random with a small table, long receiver hold at the start, then with all buckets
    settle_and_cfg(11'd7);
    hold_rx = 1'b1;
    repeat (140) send_random();
    settle_and_cfg(11'd1024);
    no_gap = 1'b1;
    repeat (40) send_random();
    no_gap = 1'b0;
    repeat (100) send_random();

    @(negedge clk_i);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (200) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("** tag_posting_index: PASSED **");
    end else begin
      $display("** tag_posting_index: FAILED **");
    end
    $finish;
  end

endmodule
